[design/rtcb_pkg.sv]
// rtcb_pkg: shared types and constants of the raster to column band framer
// holds frame byte codes, the internal command and result structs
// no dependencies
package rtcb_pkg;

  localparam int unsigned PW_W        = 9;
  localparam int unsigned RP_W        = 10;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [PW_W-1:0] PW_RESET = 9'd384;

  localparam logic [7:0] CODE_ESC = 8'h1b;
  localparam logic [7:0] CODE_K   = 8'h4b;
  localparam logic [7:0] CODE_LF  = 8'h0a;
  localparam logic [7:0] CODE_CR  = 8'h0d;
  localparam logic [7:0] TOP_BIT  = 8'h80;

  // header layout: esc, 'K', width low, width high, then column bytes
  localparam int unsigned HDR_LEN = 4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET,
    OP_CLEAR
  } ram_op_e;

  typedef struct packed {
    logic       pixel_taken;
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    ram_op_e    op;
    logic [7:0] mask;
    res_t       res;
  } cmd_t;

endpackage

[design/rtcb_ram.sv]
// rtcb_ram: generic simple dual-port ram with registered read
// one write and one read port, read returns old data on a same-address write
// no dependencies
module rtcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rtcb_front.sv]
// rtcb_front: accepts pixel and fetch transactions and classifies them
// keeps width, column, row, pending and read position state; emits commands
// depends on rtcb_pkg
module rtcb_front #(
  parameter int unsigned MAX_WIDTH = 384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rtcb_pkg::PW_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic                          dark_i,
  input  logic                          last_i,
  input  logic                          cmd_ready_i,
  output logic                          cmd_valid_o,
  output rtcb_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  cmd_addr_o
);

  import rtcb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = ((AW > RP_W) ? AW : RP_W) + 1;

  logic [PW_W-1:0]  pw_q;
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] rows_q, rows_d;
  logic             pend_q, pend_d;
  logic [RP_W-1:0]  pos_q, pos_d;

  logic [PW_W-1:0]  w_eff;
  logic [CW-1:0]    col_ext, w_ext, pos_ext;
  logic             acc;

  always_comb begin
    if (pw_q == '0) begin
      w_eff = PW_W'(1);
    end else if (int'(pw_q) > int'(MAX_WIDTH)) begin
      w_eff = PW_W'(MAX_WIDTH);
    end else begin
      w_eff = pw_q;
    end
  end

  assign col_ext = CW'(col_q);
  assign w_ext   = CW'(w_eff);
  assign pos_ext = CW'(pos_q);

  assign acc         = in_valid_i && cmd_ready_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = acc;

  always_comb begin
    col_d      = col_q;
    rows_d     = rows_q;
    pend_d     = pend_q;
    pos_d      = pos_q;
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_addr_o = col_q;

    if (!action_i) begin
      if (!pend_q) begin
        cmd_o.res.pixel_taken = 1'b1;
        if (dark_i && (col_ext < w_ext)) begin
          cmd_o.op   = OP_SET;
          cmd_o.mask = TOP_BIT >> rows_q;
        end
        if ((col_ext + CW'(1) >= w_ext) || last_i) begin
          col_d  = '0;
          rows_d = rows_q + ROW_W'(1);
          if ((rows_q == {ROW_W{1'b1}}) || last_i) begin
            rows_d = '0;
            pend_d = 1'b1;
            pos_d  = '0;
          end
        end else begin
          col_d = col_q + AW'(1);
        end
      end
    end else if (pend_q) begin
      cmd_o.res.byte_valid = 1'b1;
      pos_d = pos_q + RP_W'(1);
      if (pos_ext == CW'(0)) begin
        cmd_o.res.frame_byte = CODE_ESC;
      end else if (pos_ext == CW'(1)) begin
        cmd_o.res.frame_byte = CODE_K;
      end else if (pos_ext == CW'(2)) begin
        cmd_o.res.frame_byte = w_ext[7:0];
      end else if (pos_ext == CW'(3)) begin
        cmd_o.res.frame_byte = 8'(w_ext >> 8);
      end else if (pos_ext < w_ext + CW'(HDR_LEN)) begin
        // column byte comes from the band store, cleared on the way
        cmd_o.op   = OP_CLEAR;
        cmd_addr_o = AW'(pos_ext - CW'(HDR_LEN));
      end else if (pos_ext == w_ext + CW'(HDR_LEN)) begin
        cmd_o.res.frame_byte = CODE_LF;
      end else begin
        cmd_o.res.frame_byte = CODE_CR;
        cmd_o.res.frame_end  = 1'b1;
        pend_d = 1'b0;
        pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= PW_RESET;
      col_q  <= '0;
      rows_q <= '0;
      pend_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        pw_q <= cfg_data_i;
      end
      if (acc) begin
        col_q  <= col_d;
        rows_q <= rows_d;
        pend_q <= pend_d;
        pos_q  <= pos_d;
      end
    end
  end

endmodule

[design/rtcb_back.sv]
// rtcb_back: carries out commands on the band store and queues the results
// holds the band store ram, a write bypass, the clearing pass and a result fifo
// depends on rtcb_pkg and rtcb_ram
module rtcb_back #(
  parameter int unsigned MAX_WIDTH = 384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  rtcb_pkg::cmd_t                cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  cmd_addr_i,
  output logic                          cmd_ready_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output rtcb_pkg::res_t                res_o
);

  import rtcb_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic          s1_valid_q;
  cmd_t          s1_cmd_q;
  logic [AW-1:0] s1_addr_q;

  logic          fwd_hit_q, fwd_hit_d;
  logic [7:0]    fwd_data_q;

  logic          re;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic [7:0]    cur_data;
  res_t          s1_res;

  res_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  rtcb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cmd_addr_i),
    .rdata_o (rdata)
  );

  assign re = cmd_valid_i && (cmd_i.op != OP_NONE);

  // the write of the previous command lands in the same cycle as this read
  assign cur_data = fwd_hit_q ? fwd_data_q : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = s1_addr_q;
    wdata = '0;
    if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
    end else if (s1_valid_q) begin
      case (s1_cmd_q.op)
        OP_SET: begin
          we    = 1'b1;
          wdata = cur_data | s1_cmd_q.mask;
        end
        OP_CLEAR: begin
          we = 1'b1;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign fwd_hit_d = re && we && (cmd_addr_i == waddr);

  always_comb begin
    s1_res = s1_cmd_q.res;
    if (s1_cmd_q.op == OP_CLEAR) begin
      s1_res.frame_byte = cur_data;
    end
  end

  assign pop         = (cnt_q != '0) && res_ready_i;
  assign res_valid_o = (cnt_q != '0);
  assign res_o       = fifo_q[rd_ptr_q];

  // credit: room for the staged command and one more in the fifo
  assign cmd_ready_o = !clr_busy_q &&
                       ((cnt_q + CNT_W'(s1_valid_q)) <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      s1_valid_q <= cmd_valid_i;
      fwd_hit_q  <= fwd_hit_d;
      if (s1_valid_q) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(s1_valid_q) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      s1_cmd_q  <= cmd_i;
      s1_addr_q <= cmd_addr_i;
    end
    fwd_data_q <= wdata;
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= s1_res;
    end
  end

endmodule

[design/raster_to_column_band_framer.sv]
// raster_to_column_band_framer: top level of the 8-dot column band framer
// ties the front classifier to the back band store and result queue
// depends on rtcb_pkg, rtcb_front, rtcb_back and rtcb_ram
//
// Pixels come in one per transaction (tuser[0] = 0) and are packed into
// column bytes of an 8-row band, first row in bit 7; after eight rows or the
// image's last pixel a bit-image frame becomes pending and fetch transactions
// (tuser[0] = 1) read it out byte by byte: esc, 'K', width low, width high,
// the column bytes, lf, cr. Every input transaction yields exactly one result
// transaction. One transaction is accepted per clock cycle while the result
// fifo has room; its result is registered in the command stage and then in
// the four-entry result fifo, which absorbs back-pressure. After reset the band
// store is cleared in a pass over all MAX_WIDTH addresses during which no
// input transaction is accepted; print_width writes are taken at any time.
module raster_to_column_band_framer #(
  parameter int unsigned MAX_WIDTH = 384
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rtcb_pkg::PW_W-1:0] cfg_data_i,   // print_width
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [0] dark_pixel, [7:1] zero
  input  logic [0:0]                s_axis_tuser,  // [0] action
  input  logic                      s_axis_tlast,  // last_of_image
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] frame_byte
  output logic [1:0]                m_axis_tuser,  // [0] pixel_taken, [1] byte_valid
  output logic                      m_axis_tlast   // frame_end
);

  import rtcb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic          cmd_valid;
  logic          cmd_ready;
  cmd_t          cmd;
  logic [AW-1:0] cmd_addr;
  res_t          res;

  assign cfg_ready_o = 1'b1;

  rtcb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .dark_i      (s_axis_tdata[0]),
    .last_i      (s_axis_tlast),
    .cmd_ready_i (cmd_ready),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_addr_o  (cmd_addr)
  );

  rtcb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_addr_i  (cmd_addr),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.frame_byte;
  assign m_axis_tuser = {res.byte_valid, res.pixel_taken};
  assign m_axis_tlast = res.frame_end;

endmodule

[tb/sv/tb_raster_to_column_band_framer.sv]
// tb_raster_to_column_band_framer: self-checking testbench of the column band framer
// predicts each result from its own copy of the band store and frame reader state
// depends on rtcb_pkg and raster_to_column_band_framer
module tb_raster_to_column_band_framer;
  import rtcb_pkg::*;

  localparam int MAXW        = 384;
  localparam int WDOG_LIMIT  = 4000;
  localparam int RX_HOLD_CYC = 300;
  // total input transactions the run aims for
  localparam int ITEM_TARGET = 2000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [PW_W-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [0] dark_pixel, [7:1] zero
  logic [0:0]          s_axis_tuser  = '0;  // [0] action
  logic                s_axis_tlast  = 1'b0; // last_of_image
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [7:0] frame_byte
  logic [1:0]          m_axis_tuser;        // [0] pixel_taken, [1] byte_valid
  logic                m_axis_tlast;        // frame_end

  // predicted block state
  logic [PW_W-1:0]     width_q;
  logic [7:0]          band_q [MAXW];
  logic [8:0]          col_q;
  logic [ROW_W-1:0]    rows_q;
  logic                pend_q;
  logic [RP_W-1:0]     rpos_q;
  res_t                band_results_q [$];

  int  err_cnt        = 0;
  int  items_sent     = 0;
  int  frames_read    = 0;
  int  pushes_refused = 0;
  int  wdog_cnt       = 0;
  int  rx_stall       = 0;
  bit  tx_idle_on     = 1'b1;
  bit  rx_idle_on     = 1'b1;
  bit  hold_rx        = 1'b0;

  always #5 clk_i = ~clk_i;

  raster_to_column_band_framer #(
    .MAX_WIDTH(MAXW)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic int active_width();
    int w;
    w = int'(width_q);
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic res_t predict_band_result(logic act, logic dark, logic last);
    res_t r;
    int   w;
    int   p;
    r = '0;
    w = active_width();
    if (!act) begin
      if (pend_q) begin
        pushes_refused++;
      end else begin
        r.pixel_taken = 1'b1;
        if (dark && int'(col_q) < w) band_q[col_q] = band_q[col_q] | (TOP_BIT >> rows_q);
        if (int'(col_q) + 1 >= w || last) begin
          col_q  = '0;
          rows_q = rows_q + 1'b1;
          if (rows_q == '0 || last) begin
            rows_q = '0;
            pend_q = 1'b1;
            rpos_q = '0;
          end
        end else begin
          col_q = col_q + 1'b1;
        end
      end
    end else if (pend_q) begin
      p = int'(rpos_q);
      r.byte_valid = 1'b1;
      if (p == 0) begin
        r.frame_byte = CODE_ESC;
      end else if (p == 1) begin
        r.frame_byte = CODE_K;
      end else if (p == 2) begin
        r.frame_byte = w[7:0];
      end else if (p == 3) begin
        r.frame_byte = w[15:8];
      end else if (p < HDR_LEN + w) begin
        r.frame_byte         = band_q[p - HDR_LEN];
        band_q[p - HDR_LEN] = '0;
      end else if (p == HDR_LEN + w) begin
        r.frame_byte = CODE_LF;
      end else begin
        r.frame_byte = CODE_CR;
        r.frame_end  = 1'b1;
      end
      if (r.frame_end) begin
        pend_q = 1'b0;
        rpos_q = '0;
        frames_read++;
      end else begin
        rpos_q = rpos_q + 1'b1;
      end
    end
    return r;
  endfunction

  // valid stays high between back-to-back transactions
  task automatic send_item(input logic act, input logic dark, input logic last);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, dark};
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    band_results_q.push_back(predict_band_result(act, dark, last));
    items_sent++;
  endtask

  task automatic push_run(input int n, input bit end_image);
    for (int i = 0; i < n; i++) begin
      send_item(1'b0, 1'($urandom_range(0, 1)), end_image && i == n - 1);
    end
  endtask

  task automatic drain_frame(input bit noisy);
    while (pend_q) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_item(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // every transaction yields a result, so an empty queue means the block is idle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (band_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [PW_W-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    width_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (band_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got tdata %0h tuser %0b tlast %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = band_results_q.pop_front();
        check_field("pixel_taken", 8'(want.pixel_taken), 8'(m_axis_tuser[0]));
        check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser[1]));
        check_field("frame_byte", want.frame_byte, m_axis_tdata);
        check_field("frame_end", 8'(want.frame_end), 8'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wdog_cnt = 0;
    end else begin
      wdog_cnt++;
    end
    if (wdog_cnt >= WDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WDOG_LIMIT, band_results_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYC) @(negedge clk_i);
        hold_rx  = 1'b0;
        rx_stall = 0;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall = draw_gap();
      end
    end
  end

  task automatic test_idle_fetch();
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b1, 1'b1, 1'b1);
  endtask

  // zero width acts as one column; a full band of eight rows frames itself
  task automatic test_full_band_single_column();
    logic [7:0] pattern;
    pattern = 8'b1011_0001;
    write_width('0);
    for (int i = 0; i < 8; i++) send_item(1'b0, pattern[7 - i], 1'b0);
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b0, 1'b0, 1'b0);
    drain_frame(1'b0);
  endtask

  task automatic test_partial_band();
    write_width(9'd8);
    push_run(24, 1'b1);
    drain_frame(1'b0);
  endtask

  task automatic test_last_mid_row();
    write_width(9'd6);
    push_run(6, 1'b0);
    push_run(3, 1'b1);
    drain_frame(1'b0);
  endtask

  task automatic test_width_change_mid_row();
    write_width(9'd12);
    push_run(7, 1'b0);
    write_width(9'd5);
    send_item(1'b0, 1'b1, 1'b0);
    push_run(5, 1'b1);
    drain_frame(1'b0);
  endtask

  // shrink the width halfway through a frame; the cut-off columns show up later
  task automatic test_width_change_pending();
    write_width(9'd10);
    push_run(20, 1'b1);
    repeat (7) send_item(1'b1, 1'b0, 1'b0);
    write_width(9'd4);
    drain_frame(1'b0);
    write_width(9'd10);
    push_run(10, 1'b1);
    drain_frame(1'b0);
  endtask

  task automatic test_max_width();
    write_width(9'd384);
    push_run(384, 1'b1);
    drain_frame(1'b0);
  endtask

  task automatic test_width_clamp();
    write_width(9'h1ff);
    send_item(1'b0, 1'b1, 1'b1);
    drain_frame(1'b0);
  endtask

  task automatic test_backpressure();
    write_width(9'd7);
    tx_idle_on = 1'b0;
    hold_rx    = 1'b1;
    repeat (32) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    drain_frame(1'b0);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int stop_at;
    int pick;
    int rows;
    int n;
    int cnt;
    bit early;
    stop_at = ITEM_TARGET;
    while (items_sent < stop_at) begin
      tx_idle_on = $urandom_range(0, 2) != 0;
      rx_idle_on = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) write_width('0);
        else if (pick == 1) write_width(PW_W'($urandom_range(385, 511)));
        else if (pick == 2) write_width(PW_W'($urandom_range(65, 384)));
        else if (pick < 7) write_width(PW_W'($urandom_range(17, 64)));
        else write_width(PW_W'($urandom_range(1, 16)));
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
      drain_frame(1'b1);
      // one band of random pixels, sometimes cut short by an early image end
      rows = active_width() > 48 ? 1 : $urandom_range(1, 8);
      n    = rows * active_width();
      cnt  = 0;
      while (!pend_q) begin
        cnt++;
        early = $urandom_range(0, 199) == 0;
        send_item(1'b0, 1'($urandom_range(0, 1)),
                  (cnt >= n && (rows < 8 || $urandom_range(0, 1) == 1)) || early);
      end
      drain_frame(1'b1);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    width_q = PW_RESET;
    foreach (band_q[i]) band_q[i] = '0;
    col_q  = '0;
    rows_q = '0;
    pend_q = 1'b0;
    rpos_q = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_fetch();
    test_full_band_single_column();
    test_partial_band();
    test_last_mid_row();
    test_width_change_mid_row();
    test_width_change_pending();
    test_max_width();
    test_width_clamp();
    test_backpressure();
    test_random();

    wait_idle();
    $display("covered %0d input transactions, %0d frames read out, %0d pushes refused",
             items_sent, frames_read, pushes_refused);
    $display("widths ranged over zero, one, 384 and clamped values, with a long output stall");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
